// ===== rtl/core/stt_pkg.sv =====
// Shared types and constants for the software timer table core.
// Depends on nothing; every other file of the core imports it.
`default_nettype none

package stt_pkg;

    // Default number of timer slots.
    localparam int TimerSlotsDefault = 16;

    // Function codes of an input beat.
    localparam logic [1:0] FuncSched  = 2'd0;
    localparam logic [1:0] FuncCancel = 2'd1;
    localparam logic [1:0] FuncTick   = 2'd2;
    localparam logic [1:0] FuncNone   = 2'd3;

    // Result kinds.
    localparam logic [1:0] KindSched = 2'd0;
    localparam logic [1:0] KindFire  = 2'd1;
    localparam logic [1:0] KindDone  = 2'd2;
    localparam logic [1:0] KindFull  = 2'd3;

    // Command classes handed from the front to the back.
    typedef enum logic [1:0] {
        OP_SCHED,
        OP_CANCEL,
        OP_TICK
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] now_time;
        logic [31:0] interval;
        logic        repeat_mode;
        logic [31:0] cancel_id;
    } cmd_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCHED_END,
        ST_CANCEL_END,
        ST_TICK_EVAL
    } st_t;

endpackage

`default_nettype wire

// ===== rtl/core/stt_front.sv =====
// Front end: accepts input beats, classifies them and queues commands.
// Depends on stt_pkg.
`default_nettype none

module stt_front
    import stt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  func,
    input  wire logic [31:0] now_time,
    input  wire logic [31:0] interval,
    input  wire logic        repeat_mode,
    input  wire logic [31:0] cancel_id,
    output logic             q_valid,
    output cmd_t             q_cmd,
    input  wire logic        q_pop
);

    cmd_t        fifo_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    cmd_t        cmd_in;

    // Classify the beat; the unused function code is kept out of the queue by the push condition.
    always_comb
    begin
        cmd_in.now_time    = now_time;
        cmd_in.interval    = interval;
        cmd_in.repeat_mode = repeat_mode;
        cmd_in.cancel_id   = cancel_id;
        unique case (func)
            FuncSched:  cmd_in.op = OP_SCHED;
            FuncCancel: cmd_in.op = OP_CANCEL;
            default:    cmd_in.op = OP_TICK;
        endcase
    end

    assign busy    = (count_reg == 2'd2);
    assign push    = start && !busy && (func != FuncNone);
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = fifo_reg[rd_ptr_reg];

    // Queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = (q_pop && q_valid) ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop && q_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    // The queue never holds more than two commands.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("command queue overfilled");

    assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !($past(count_reg) == 2'd2 && count_reg == 2'd0))
        else $error("queue drained by two in one cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_valid && !push) |=> count_reg == $past(count_reg) - 2'd1)
        else $error("queue count did not drop on pop");

endmodule

`default_nettype wire

// ===== rtl/core/stt_back.sv =====
// Back end: timer slot storage and the sequencer that carries out commands.
// Depends on stt_pkg.
`default_nettype none

module stt_back
    import stt_pkg::*;
#(
    parameter int TIMER_SLOTS = TimerSlotsDefault
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire cmd_t        q_cmd,
    output logic             q_pop,
    output logic             result_strobe,
    output logic [1:0]       kind,
    output logic [31:0]      timer_id,
    output logic             last
);

    localparam int IdxW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(TIMER_SLOTS - 1);

    // Slot storage.
    logic [TIMER_SLOTS-1:0] valid_reg, valid_next;
    logic [31:0] ent_id_reg   [TIMER_SLOTS];
    logic [31:0] ent_tgt_reg  [TIMER_SLOTS];
    logic [31:0] ent_per_reg  [TIMER_SLOTS];
    logic        ent_rep_reg  [TIMER_SLOTS];
    logic        ent_bank_reg [TIMER_SLOTS];

    // Sequencer state.
    st_t            state_reg, state_next;
    logic [IdxW-1:0] idx_reg, idx_next;
    cmd_t           cmd_reg, cmd_next;
    logic           cur_bank_reg, cur_bank_next;
    logic           tick_bank_reg, tick_bank_next;
    logic [31:0]    issued_reg, issued_next;
    logic [31:0]    prev_id_reg, prev_id_next;
    logic           have_prev_reg, have_prev_next;
    logic           fa_reg, fa_next, fb_reg, fb_next;
    logic [IdxW-1:0] sa_reg, sa_next, sb_reg, sb_next;
    logic [31:0]    best_id_reg, best_id_next;
    logic [31:0]    best_tgt_reg, best_tgt_next;
    logic [31:0]    best_per_reg, best_per_next;
    logic           best_rep_reg, best_rep_next;
    logic           strobe_reg, strobe_next;
    logic [1:0]     kind_reg, kind_next;
    logic [31:0]    id_reg, id_next;
    logic           last_reg, last_next;

    logic           ent_we, tgt_we;
    logic           e_v, e_b, e_rep;
    logic [31:0]    e_id, e_tgt, e_per;
    logic [31:0]    diff;

    assign e_v   = valid_reg[idx_reg];
    assign e_b   = ent_bank_reg[idx_reg];
    assign e_id  = ent_id_reg[idx_reg];
    assign e_tgt = ent_tgt_reg[idx_reg];
    assign e_per = ent_per_reg[idx_reg];
    assign e_rep = ent_rep_reg[idx_reg];
    assign diff  = best_tgt_reg - cmd_reg.now_time;

    assign result_strobe = strobe_reg;
    assign kind          = kind_reg;
    assign timer_id      = id_reg;
    assign last          = last_reg;

    // Next state and outputs of the sequencer.
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmd_next       = cmd_reg;
        cur_bank_next  = cur_bank_reg;
        tick_bank_next = tick_bank_reg;
        issued_next    = issued_reg;
        prev_id_next   = prev_id_reg;
        have_prev_next = have_prev_reg;
        fa_next        = fa_reg;
        fb_next        = fb_reg;
        sa_next        = sa_reg;
        sb_next        = sb_reg;
        best_id_next   = best_id_reg;
        best_tgt_next  = best_tgt_reg;
        best_per_next  = best_per_reg;
        best_rep_next  = best_rep_reg;
        valid_next     = valid_reg;
        strobe_next    = 1'b0;
        kind_next      = kind_reg;
        id_next        = id_reg;
        last_next      = last_reg;
        ent_we         = 1'b0;
        tgt_we         = 1'b0;
        q_pop          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    idx_next   = '0;
                    fa_next    = 1'b0;
                    fb_next    = 1'b0;
                    state_next = ST_SCAN;
                    if (q_cmd.op == OP_SCHED)
                    begin
                        issued_next = issued_reg + 32'd1;
                    end
                    if (q_cmd.op == OP_TICK)
                    begin
                        tick_bank_next = cur_bank_reg;
                        cur_bank_next  = ~cur_bank_reg;
                        have_prev_next = 1'b0;
                    end
                end
            end

            ST_SCAN:
            begin
                // Look at one slot per cycle.
                case (cmd_reg.op)
                    OP_SCHED:
                    begin
                        if (e_v && e_b == cur_bank_reg && e_id == issued_reg)
                        begin
                            fa_next = 1'b1;
                        end
                        if (!e_v && !fb_reg)
                        begin
                            fb_next = 1'b1;
                            sb_next = idx_reg;
                        end
                    end
                    OP_CANCEL:
                    begin
                        if (e_v && e_id == cmd_reg.cancel_id)
                        begin
                            if (!e_b && !fa_reg)
                            begin
                                fa_next = 1'b1;
                                sa_next = idx_reg;
                            end
                            if (e_b && !fb_reg)
                            begin
                                fb_next = 1'b1;
                                sb_next = idx_reg;
                            end
                        end
                    end
                    default:
                    begin
                        // Smallest id above the last one visited in this tick.
                        if (e_v && e_b == tick_bank_reg
                            && (!have_prev_reg || e_id > prev_id_reg)
                            && (!fa_reg || e_id < best_id_reg))
                        begin
                            fa_next       = 1'b1;
                            sa_next       = idx_reg;
                            best_id_next  = e_id;
                            best_tgt_next = e_tgt;
                            best_per_next = e_per;
                            best_rep_next = e_rep;
                        end
                    end
                endcase
                if (idx_reg == LastIdx)
                begin
                    case (cmd_reg.op)
                        OP_SCHED:  state_next = ST_SCHED_END;
                        OP_CANCEL: state_next = ST_CANCEL_END;
                        default:   state_next = ST_TICK_EVAL;
                    endcase
                end
                else
                begin
                    idx_next = idx_reg + IdxW'(1);
                end
            end

            ST_SCHED_END:
            begin
                strobe_next = 1'b1;
                id_next     = issued_reg;
                last_next   = 1'b1;
                if (fa_reg)
                begin
                    kind_next = KindSched;
                end
                else if (fb_reg)
                begin
                    kind_next          = KindSched;
                    ent_we             = 1'b1;
                    valid_next[sb_reg] = 1'b1;
                end
                else
                begin
                    kind_next = KindFull;
                end
                state_next = ST_IDLE;
            end

            ST_CANCEL_END:
            begin
                if (fa_reg)
                begin
                    valid_next[sa_reg] = 1'b0;
                end
                else if (fb_reg)
                begin
                    valid_next[sb_reg] = 1'b0;
                end
                state_next = ST_IDLE;
            end

            ST_TICK_EVAL:
            begin
                if (!fa_reg)
                begin
                    strobe_next = 1'b1;
                    kind_next   = KindDone;
                    id_next     = 32'd0;
                    last_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    if (diff[31])
                    begin
                        strobe_next = 1'b1;
                        kind_next   = KindFire;
                        id_next     = best_id_reg;
                        last_next   = 1'b0;
                        if (best_rep_reg)
                        begin
                            tgt_we = 1'b1;
                        end
                        else
                        begin
                            valid_next[sa_reg] = 1'b0;
                        end
                    end
                    prev_id_next   = best_id_reg;
                    have_prev_next = 1'b1;
                    fa_next        = 1'b0;
                    idx_next       = '0;
                    state_next     = ST_SCAN;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            valid_reg     <= '0;
            cur_bank_reg  <= 1'b0;
            tick_bank_reg <= 1'b0;
            issued_reg    <= 32'd0;
            have_prev_reg <= 1'b0;
            fa_reg        <= 1'b0;
            fb_reg        <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            valid_reg     <= valid_next;
            cur_bank_reg  <= cur_bank_next;
            tick_bank_reg <= tick_bank_next;
            issued_reg    <= issued_next;
            have_prev_reg <= have_prev_next;
            fa_reg        <= fa_next;
            fb_reg        <= fb_next;
            strobe_reg    <= strobe_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        prev_id_reg  <= prev_id_next;
        sa_reg       <= sa_next;
        sb_reg       <= sb_next;
        best_id_reg  <= best_id_next;
        best_tgt_reg <= best_tgt_next;
        best_per_reg <= best_per_next;
        best_rep_reg <= best_rep_next;
        kind_reg     <= kind_next;
        id_reg       <= id_next;
        last_reg     <= last_next;
    end

    // Slot storage writes: new timer on schedule, re-arm on periodic fire.
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_id_reg[sb_reg]   <= issued_reg;
            ent_tgt_reg[sb_reg]  <= cmd_reg.now_time + cmd_reg.interval;
            ent_per_reg[sb_reg]  <= cmd_reg.interval;
            ent_rep_reg[sb_reg]  <= cmd_reg.repeat_mode;
            ent_bank_reg[sb_reg] <= cur_bank_reg;
        end
        if (tgt_we)
        begin
            ent_tgt_reg[sa_reg] <= cmd_reg.now_time + best_per_reg;
        end
    end

    // A result only follows a closing state.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> ($past(state_reg) == ST_SCHED_END
                        || $past(state_reg) == ST_TICK_EVAL))
        else $error("result without a closing state");

    // A fire result is never the last beat of its tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && kind_reg == KindFire) |-> !last_reg)
        else $error("fire result marked last");

    // Tick done always closes the command.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && kind_reg == KindDone) |-> (last_reg && state_reg == ST_IDLE))
        else $error("tick done not final");

    // A new command is only taken while idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == ST_IDLE)
        else $error("command taken while busy");

endmodule

`default_nettype wire

// ===== rtl/core/software_timer_table_core.sv =====
// Top level of the software timer table: front end, command queue, back end.
// Depends on stt_pkg, stt_front and stt_back.
//
//   channel  | handshake              | beat fields
//   ---------+------------------------+---------------------------------------
//   input    | start high, busy low   | func, now_time, interval,
//            |                        | repeat_mode, cancel_id
//   result   | result_strobe, 1 cycle | kind, timer_id, last
//
// Schedule and cancel scan every slot in the back end and then close; a tick
// scans the slots once per armed slot in the ticked bank and once more to
// finish, with the slot scan visiting one slot per cycle.
// The front queue holds two commands, so busy rises only when both wait.
// Reset clears all slots, the bank and the id counter at once.
// Results cannot be stalled: each is shown for exactly one cycle.
`default_nettype none

module software_timer_table_core
    import stt_pkg::*;
#(
    parameter int TIMER_SLOTS = TimerSlotsDefault
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  func,
    input  wire logic [31:0] now_time,
    input  wire logic [31:0] interval,
    input  wire logic        repeat_mode,
    input  wire logic [31:0] cancel_id,
    output logic             result_strobe,
    output logic [1:0]       kind,
    output logic [31:0]      timer_id,
    output logic             last
);

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    // Accept and queue commands.
    stt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .now_time    (now_time),
        .interval    (interval),
        .repeat_mode (repeat_mode),
        .cancel_id   (cancel_id),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop)
    );

    // Carry out commands against the slot table.
    stt_back #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop),
        .result_strobe (result_strobe),
        .kind          (kind),
        .timer_id      (timer_id),
        .last          (last)
    );

endmodule

`default_nettype wire
